/* src/jsc_pkg.sv */
// Shared constants and the month-start table for the seconds-to-date converter.
// No dependencies.
package jsc_pkg;

  localparam int SEC_W   = 31;
  localparam int DAYS_W  = 15;
  localparam int SOD_W   = 17;
  localparam int QUAD_W  = 5;
  localparam int QREM_W  = 11;
  localparam int MODH_W  = 12;
  localparam int WDN_W   = 15;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_PER_QUAD = 1461;
  localparam int DAYS_PER_WEEK = 7;
  localparam int WDAY_OFFSET   = 6;
  localparam int BASE_YEAR     = 2000;
  localparam int YEAR1_START   = 366;
  localparam int YEAR2_START   = 731;
  localparam int YEAR3_START   = 1096;
  localparam int LAST_MONTH    = 12;

  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] v;
    case (mon)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/jsc_divc.sv */
// Three-stage divide/modulo by a constant: reciprocal multiply, back-multiply,
// then a single compare-and-subtract correction. Uses no package.
module jsc_divc #(
  parameter int NW = 31,
  parameter int QW = 15,
  parameter int D  = 86400,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [NW-1:0]          n,
  input  logic [SW-1:0]          side,
  output logic [QW-1:0]          q,
  output logic [$clog2(D)-1:0]   r,
  output logic [SW-1:0]          side_o
);

  localparam int CW = $clog2(D);
  localparam int K  = NW + CW;
  localparam logic [NW:0] RECIP = (NW+1)'((64'd1 << K) / D);

  logic [2*NW:0] prod;
  logic [NW-1:0] n_a, n_b, p_b, diff;
  logic [QW-1:0] q0_a, q0_b;
  logic [SW-1:0] side_a, side_b;

  assign prod = (2*NW+1)'(n) * (2*NW+1)'(RECIP);
  assign diff = n_b - p_b;

  always_ff @(posedge clk) begin
    if (en) begin
      n_a    <= n;
      side_a <= side;
      q0_a   <= QW'(prod >> K);
      n_b    <= n_a;
      side_b <= side_a;
      q0_b   <= q0_a;
      p_b    <= NW'(q0_a * D);
      side_o <= side_b;
      if (diff >= NW'(D)) begin
        q <= q0_b + QW'(1);
        r <= CW'(diff - NW'(D));
      end else begin
        q <= q0_b;
        r <= CW'(diff);
      end
    end
  end

endmodule

/* src/jsc_ymd.sv */
// Year, month, day and day of year from a four-year block and day offset.
// Depends on jsc_pkg.
module jsc_ymd (
  input  logic                        clk,
  input  logic                        en,
  input  logic [jsc_pkg::QUAD_W-1:0]  quad,
  input  logic [jsc_pkg::QREM_W-1:0]  qrem,
  output logic [11:0]                 year,
  output logic [3:0]                  month,
  output logic [4:0]                  day_of_month,
  output logic [8:0]                  day_of_year
);

  logic [1:0]                 yq_a;
  logic [8:0]                 off_a, off_b;
  logic [jsc_pkg::QUAD_W-1:0] quad_a, quad_b;
  logic                       leap_b;
  logic [3:0]                 mon_b;
  logic [1:0]                 yq_b;
  logic [1:0]                 yq_next;
  logic [8:0]                 off_next;
  logic [3:0]                 mon_next;
  logic [8:0]                 start_b;
  logic                       leap_a;

  function automatic logic [jsc_pkg::QREM_W-1:0] QREM_CMP(input int v);
    return jsc_pkg::QREM_W'(v);
  endfunction

  always_comb begin
    if (qrem >= QREM_CMP(jsc_pkg::YEAR3_START)) begin
      yq_next  = 2'd3;
      off_next = 9'(qrem - QREM_CMP(jsc_pkg::YEAR3_START));
    end else if (qrem >= QREM_CMP(jsc_pkg::YEAR2_START)) begin
      yq_next  = 2'd2;
      off_next = 9'(qrem - QREM_CMP(jsc_pkg::YEAR2_START));
    end else if (qrem >= QREM_CMP(jsc_pkg::YEAR1_START)) begin
      yq_next  = 2'd1;
      off_next = 9'(qrem - QREM_CMP(jsc_pkg::YEAR1_START));
    end else begin
      yq_next  = 2'd0;
      off_next = 9'(qrem);
    end
  end

  assign leap_a = (yq_a == 2'd0);

  always_comb begin
    logic [8:0] st;
    mon_next = 4'd1;
    for (int m = 2; m <= jsc_pkg::LAST_MONTH; m++) begin
      st = jsc_pkg::month_start(4'(m)) + ((leap_a && m > 2) ? 9'd1 : 9'd0);
      if (off_a >= st) mon_next = 4'(m);
    end
  end

  assign start_b = jsc_pkg::month_start(mon_b) + ((leap_b && mon_b > 4'd2) ? 9'd1 : 9'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      yq_a         <= yq_next;
      off_a        <= off_next;
      quad_a       <= quad;
      yq_b         <= yq_a;
      off_b        <= off_a;
      quad_b       <= quad_a;
      leap_b       <= leap_a;
      mon_b        <= mon_next;
      month        <= mon_b;
      day_of_month <= 5'(off_b - start_b + 9'd1);
      day_of_year  <= off_b + 9'd1;
      year         <= 12'(jsc_pkg::BASE_YEAR) + {5'd0, quad_b, 2'b00} + {10'd0, yq_b};
    end
  end

endmodule

/* src/julian_seconds_to_calendar_date.sv */
// Top level of the seconds-to-calendar converter.
// Depends on jsc_pkg, jsc_divc and jsc_ymd.
//
// Input channel: seconds_since_epoch with in_valid/in_ready. Output channel:
// second, minute, hour, day_of_month, month, year, weekday, day_of_year with
// out_valid/out_ready. Each input transaction gives exactly one output
// transaction, in order.
// A transaction passes nine register stages: three constant dividers of three
// stages each in series (by 86400; then by 3600, 1461 and 7 side by side; then by
// 60 beside the year/month stages). Throughput is one transaction per cycle while
// the output is not stalled. The whole pipeline advances together: when the
// output holds a transaction that is not taken, every stage holds and in_ready
// drops, so nothing is lost or repeated. Empty stages move along with the rest;
// a bubble is not squeezed out under a stall.
// Synchronous reset clears the stage valid bits; data registers are not reset.
module julian_seconds_to_calendar_date (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jsc_pkg::SEC_W-1:0] seconds_since_epoch,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [5:0]                second,
  output logic [5:0]                minute,
  output logic [4:0]                hour,
  output logic [4:0]                day_of_month,
  output logic [3:0]                month,
  output logic [11:0]               year,
  output logic [2:0]                weekday,
  output logic [8:0]                day_of_year
);

  localparam int LAT = 9;

  logic [LAT-1:0]               vld;
  logic                         en;
  logic [jsc_pkg::DAYS_W-1:0]   days;
  logic [jsc_pkg::SOD_W-1:0]    sod;
  logic [4:0]                   hour_b;
  logic [jsc_pkg::MODH_W-1:0]   moh;
  logic [jsc_pkg::QUAD_W-1:0]   quad;
  logic [jsc_pkg::QREM_W-1:0]   qrem;
  logic [2:0]                   wrem;
  logic [jsc_pkg::WDN_W-1:0]    wdn;
  logic [7:0]                   hw_side, hw_out;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  jsc_divc #(.NW(jsc_pkg::SEC_W), .QW(jsc_pkg::DAYS_W), .D(jsc_pkg::SECS_PER_DAY), .SW(1))
    u_day (.clk, .en, .n(seconds_since_epoch), .side(1'b0), .q(days), .r(sod), .side_o());

  jsc_divc #(.NW(jsc_pkg::SOD_W), .QW(5), .D(jsc_pkg::SECS_PER_HOUR), .SW(1))
    u_hour (.clk, .en, .n(sod), .side(1'b0), .q(hour_b), .r(moh), .side_o());

  jsc_divc #(.NW(jsc_pkg::DAYS_W), .QW(jsc_pkg::QUAD_W), .D(jsc_pkg::DAYS_PER_QUAD), .SW(1))
    u_quad (.clk, .en, .n(days), .side(1'b0), .q(quad), .r(qrem), .side_o());

  assign wdn = days + jsc_pkg::WDN_W'(jsc_pkg::WDAY_OFFSET);

  jsc_divc #(.NW(jsc_pkg::WDN_W), .QW(12), .D(jsc_pkg::DAYS_PER_WEEK), .SW(1))
    u_week (.clk, .en, .n(wdn), .side(1'b0), .q(), .r(wrem), .side_o());

  assign hw_side = {hour_b, wrem + 3'd1};

  jsc_divc #(.NW(jsc_pkg::MODH_W), .QW(6), .D(jsc_pkg::SECS_PER_MIN), .SW(8))
    u_min (.clk, .en, .n(moh), .side(hw_side), .q(minute), .r(second), .side_o(hw_out));

  assign hour    = hw_out[7:3];
  assign weekday = hw_out[2:0];

  jsc_ymd u_ymd (
    .clk, .en, .quad, .qrem,
    .year, .month, .day_of_month, .day_of_year
  );

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12))
    else $error("month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24))
    else $error("time of day out of range");

  a_doy_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (day_of_year >= 9'(day_of_month) && weekday != 3'd0))
    else $error("day of year or weekday inconsistent");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(second))
    else $error("output changed under stall");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for julian_seconds_to_calendar_date.
// Predicts every calendar field from the seconds count; depends on jsc_pkg and the RTL.
module tb_top;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
  } date_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [jsc_pkg::SEC_W-1:0] seconds_since_epoch = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  date_t                     got;

  date_t pending_dates[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  logic  hold_start = 1'b0;
  logic  hold_seen = 1'b0;
  int    hold_left = 0;

  always #10 clk = ~clk;

  julian_seconds_to_calendar_date i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .seconds_since_epoch(seconds_since_epoch),
    .out_valid(out_valid), .out_ready(out_ready),
    .second(got.second), .minute(got.minute), .hour(got.hour),
    .day_of_month(got.day_of_month), .month(got.month), .year(got.year),
    .weekday(got.weekday), .day_of_year(got.day_of_year)
  );

  function automatic date_t calendar_of(input logic [30:0] s);
    int unsigned jd, w, x, a, b, c, d, e, f, mday, mon, yr, doy;
    int unsigned starts[13];
    date_t r;
    starts = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    jd = s / 86400 + 2451545;
    w = (4 * jd - 7468865) / 146097;
    x = w / 4;
    a = jd + w + 1 - x;
    b = a + 1524;
    c = (20 * b - 2442) / 7305;
    d = (c * 1461) / 4;
    e = ((b - d) * 10000) / 306001;
    f = (306001 * e) / 10000;
    mday = (b - d) - f;
    mon = (e < 14) ? e - 1 : e - 13;
    yr = (mon < 3) ? c - 4715 : c - 4716;
    doy = mday + ((mon >= 1 && mon <= 12) ? starts[mon] : 0);
    if (mon > 2 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) doy++;
    r.second = 6'(s % 60);
    r.minute = 6'((s / 60) % 60);
    r.hour = 5'((s / 3600) % 24);
    r.day_of_month = 5'(mday);
    r.month = 4'(mon);
    r.year = 12'(yr);
    r.weekday = 3'(((jd + 1) % 7) + 1);
    r.day_of_year = 9'(doy);
    return r;
  endfunction

  task automatic send_seconds(input logic [30:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    seconds_since_epoch <= s;
    pending_dates.push_back(calendar_of(s));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_start && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 200;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    date_t exp_d;
    if (!rst && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        exp_d = pending_dates.pop_front();
        if (got.second !== exp_d.second) begin
          $error("second exp %0d got %0d", exp_d.second, got.second); errors++; end
        if (got.minute !== exp_d.minute) begin
          $error("minute exp %0d got %0d", exp_d.minute, got.minute); errors++; end
        if (got.hour !== exp_d.hour) begin
          $error("hour exp %0d got %0d", exp_d.hour, got.hour); errors++; end
        if (got.day_of_month !== exp_d.day_of_month) begin
          $error("day_of_month exp %0d got %0d", exp_d.day_of_month, got.day_of_month);
          errors++;
        end
        if (got.month !== exp_d.month) begin
          $error("month exp %0d got %0d", exp_d.month, got.month); errors++; end
        if (got.year !== exp_d.year) begin
          $error("year exp %0d got %0d", exp_d.year, got.year); errors++; end
        if (got.weekday !== exp_d.weekday) begin
          $error("weekday exp %0d got %0d", exp_d.weekday, got.weekday); errors++; end
        if (got.day_of_year !== exp_d.day_of_year) begin
          $error("day_of_year exp %0d got %0d", exp_d.day_of_year, got.day_of_year);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Field extremes, leap days, century leap year 2000, year ends.
  task automatic test_directed();
    logic [30:0] pts[$];
    pts = '{31'd0, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
            31'd2678400, 31'd5097599, 31'd5097600, 31'd5183999, 31'd5184000,
            31'd31535999, 31'd31622399, 31'd31622400, 31'd63158399,
            31'd131328000, 31'd131414400, 31'd946684799, 31'd2147483647,
            31'h2AAAAAAA, 31'h55555555, 31'h7FFF0000, 31'd1234567890};
    foreach (pts[i]) send_seconds(pts[i]);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    logic [30:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = 31'($urandom);
        1: s = 31'($urandom_range(24 * 86400) + 86400 * (366 * $urandom_range(0, 68) / 1));
        2: s = 31'(86400 * $urandom_range(24855) + $urandom_range(1) * 86399);
        default: s = 31'($urandom_range(31'h7FFFFFFF, 31'h7F000000));
      endcase
      send_seconds(s);
    end
  endtask

  task automatic test_backpressure();
    hold_start = 1'b1;
    send_idle_pct = 0;
    test_random(40);
    wait_drained();
  endtask

  initial begin : limit
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 14; recv_idle_pct = 54;
    test_directed();
    test_random(200);
    send_idle_pct = 54; recv_idle_pct = 14;
    test_random(200);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(150);
    test_backpressure();
    wait_drained();
    repeat (30) @(posedge clk);
    if (errors == 0 && pending_dates.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* sim.f */
src/jsc_pkg.sv
src/jsc_divc.sv
src/jsc_ymd.sv
src/julian_seconds_to_calendar_date.sv
dv/tb_top.sv
